// File: rtl/tca_pkg.sv
`timescale 1ns / 1ps
// tca_pkg: shared types, register map and constants of the TSCH cell allocator.
// No dependencies.
package tca_pkg;

    localparam int SLOT_W    = 10;
    localparam int CHAN_W    = 4;
    localparam int ADDR_W    = 16;
    localparam int GROUP_W   = 5;
    localparam int NCOUNT_W  = 9;
    localparam int PADDR_W   = 4;
    localparam int PDATA_W   = 32;

    localparam int DEF_MAX_NODES = 256;
    localparam int DEF_MAX_GROUP = 16;

    localparam logic [GROUP_W-1:0]  RST_GROUP_SIZE  = 5'd1;
    localparam logic [NCOUNT_W-1:0] RST_NODE_COUNT  = 9'd0;
    localparam logic [ADDR_W-1:0]   RST_NODE_BCAST  = 16'hFFFF;
    localparam logic [ADDR_W-1:0]   RST_ROUTER_BCAST = 16'hFFFE;

    // register indexes (byte address = 4 * index)
    localparam logic [1:0] REG_GROUP_SIZE   = 2'd0;
    localparam logic [1:0] REG_NODE_COUNT   = 2'd1;
    localparam logic [1:0] REG_NODE_BCAST   = 2'd2;
    localparam logic [1:0] REG_ROUTER_BCAST = 2'd3;

    // command codes
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_NODE  = 1'b1;

    typedef struct packed {
        logic              command;
        logic [ADDR_W-1:0] node_address;
    } cmd_t;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic [CHAN_W-1:0] channel;
        logic [ADDR_W-1:0] sender;
        logic [ADDR_W-1:0] receiver;
        logic              shared;
        logic [SLOT_W-1:0] frame_length;
        logic              overflow;
        logic              last;
    } cell_t;

    typedef struct packed {
        logic [GROUP_W-1:0]  group_size;
        logic [NCOUNT_W-1:0] node_count;
        logic [ADDR_W-1:0]   node_broadcast_addr;
        logic [ADDR_W-1:0]   router_broadcast_addr;
    } cfg_t;

    // bit r set when gcd(r, g) == 1, for residues r < g
    function automatic logic [15:0] coprime_mask(input logic [GROUP_W-1:0] g);
        logic [15:0] m;
        begin
            case (g)
                5'd1:    m = 16'h0001;
                5'd2:    m = 16'h0002;
                5'd3:    m = 16'h0006;
                5'd4:    m = 16'h000A;
                5'd5:    m = 16'h001E;
                5'd6:    m = 16'h0022;
                5'd7:    m = 16'h007E;
                5'd8:    m = 16'h00AA;
                5'd9:    m = 16'h01B6;
                5'd10:   m = 16'h028A;
                5'd11:   m = 16'h07FE;
                5'd12:   m = 16'h08A2;
                5'd13:   m = 16'h1FFE;
                5'd14:   m = 16'h2A2A;
                5'd15:   m = 16'h6996;
                5'd16:   m = 16'hAAAA;
                default: m = 16'h0001;
            endcase
            return m;
        end
    endfunction

endpackage

// File: rtl/tca_regs.sv
`timescale 1ns / 1ps
// tca_regs: APB configuration registers of the cell allocator.
// Depends on tca_pkg.
module tca_regs
    import tca_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output cfg_t               cfg
);

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [1:0] idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = paddr[3:2];
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.group_size            <= RST_GROUP_SIZE;
            cfg_reg.node_count            <= RST_NODE_COUNT;
            cfg_reg.node_broadcast_addr   <= RST_NODE_BCAST;
            cfg_reg.router_broadcast_addr <= RST_ROUTER_BCAST;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_GROUP_SIZE:   cfg_reg.group_size <= pwdata[GROUP_W-1:0];
                REG_NODE_COUNT:   cfg_reg.node_count <= pwdata[NCOUNT_W-1:0];
                REG_NODE_BCAST:   cfg_reg.node_broadcast_addr <= pwdata[ADDR_W-1:0];
                REG_ROUTER_BCAST: cfg_reg.router_broadcast_addr <= pwdata[ADDR_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_GROUP_SIZE:   prdata = PDATA_W'(cfg_reg.group_size);
            REG_NODE_COUNT:   prdata = PDATA_W'(cfg_reg.node_count);
            REG_NODE_BCAST:   prdata = PDATA_W'(cfg_reg.node_broadcast_addr);
            REG_ROUTER_BCAST: prdata = PDATA_W'(cfg_reg.router_broadcast_addr);
            default:          prdata = '0;
        endcase
    end

endmodule

// File: rtl/tca_div.sv
`timescale 1ns / 1ps
// tca_div: restoring divider by the group size, one quotient bit per cycle.
// Depends on tca_pkg.
module tca_div
    import tca_pkg::*;
#(
    parameter int DW = 10
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [DW-1:0]      dividend,
    input  logic [GROUP_W-1:0] divisor,
    output logic               done,
    output logic [DW-1:0]      quotient,
    output logic [GROUP_W-1:0] remainder
);

    localparam int CW = $clog2(DW + 1);

    logic               busy_reg,  busy_next;
    logic               done_reg,  done_next;
    logic [CW-1:0]      cnt_reg,   cnt_next;
    logic [DW-1:0]      dvd_reg,   dvd_next;
    logic [GROUP_W-1:0] rem_reg,   rem_next;
    logic [GROUP_W-1:0] dsr_reg,   dsr_next;

    // shared compare-subtract
    logic [GROUP_W:0] rem_sh;
    logic [GROUP_W:0] diff;
    logic             ge;

    assign rem_sh = {rem_reg, dvd_reg[DW-1]};
    assign diff   = rem_sh - {1'b0, dsr_reg};
    assign ge     = rem_sh >= {1'b0, dsr_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CW'(DW);
            dvd_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            dvd_next = {dvd_reg[DW-2:0], ge};
            rem_next = ge ? diff[GROUP_W-1:0] : rem_sh[GROUP_W-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            dvd_reg  <= '0;
            rem_reg  <= '0;
            dsr_reg  <= 5'd1;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
            dvd_reg  <= dvd_next;
            rem_reg  <= rem_next;
            dsr_reg  <= dsr_next;
        end
    end

    assign done      = done_reg;
    assign quotient  = dvd_reg;
    assign remainder = rem_reg;

endmodule

// File: rtl/tsch_cell_allocator.sv
`timescale 1ns / 1ps
// tsch_cell_allocator: top level, command sequencer and cell output register.
// Depends on tca_pkg, tca_regs, tca_div.

// A node command passes from the accept cycle through the uplink and downlink
// cell beats, each loaded into the single output register (uplink cell, then
// downlink cell) once that register is not held by cell_stall. A start command
// runs the shared restoring divider, DW = max(10, clog2(2*MAX_NODES +
// MAX_GROUP + 2)) bits wide (10 at defaults), once for ceil(N/G) and once for
// the residue of the first frame candidate; the coprime search then steps one
// candidate per cycle, rejecting fewer candidates than the clamped group size,
// before the start cell waits for the output register. cmd_stall is high from
// acceptance until the last cell of the command is loaded into the output
// register; a new command may be taken while that cell still waits.
module tsch_cell_allocator
    import tca_pkg::*;
#(
    parameter int MAX_NODES = DEF_MAX_NODES,
    parameter int MAX_GROUP = DEF_MAX_GROUP
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               cmd_stall,
    input  cmd_t               cmd,
    output logic               cell_valid,
    input  logic               cell_stall,
    output cell_t              cell_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    localparam int DW_RAW = $clog2(2 * MAX_NODES + MAX_GROUP + 2);
    localparam int DW     = (DW_RAW > SLOT_W) ? DW_RAW : SLOT_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_N,
        ST_DIV_START,
        ST_SEARCH,
        ST_EMIT_START,
        ST_EMIT_UP,
        ST_EMIT_DOWN
    } state_t;

    cfg_t cfg;

    tca_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    state_t              state_reg,     state_next;
    logic [SLOT_W-1:0]   frame_len_reg, frame_len_next;
    logic [SLOT_W-1:0]   up_slot_reg,   up_slot_next;
    logic [SLOT_W-1:0]   dn_slot_reg,   dn_slot_next;
    logic [CHAN_W-1:0]   dn_chan_reg,   dn_chan_next;
    logic [NCOUNT_W-1:0] done_cnt_reg,  done_cnt_next;
    logic [ADDR_W-1:0]   addr_reg,      addr_next;
    logic                ovf_reg,       ovf_next;
    logic [DW-1:0]       q_reg,         q_next;
    logic [DW-1:0]       cand_reg,      cand_next;
    logic [CHAN_W-1:0]   res_reg,       res_next;
    logic                cell_valid_reg, cell_valid_next;
    cell_t               cell_reg,      cell_next;

    logic [GROUP_W-1:0]  g_eff;
    logic [DW-1:0]       n_eff;
    logic                accept;
    logic                out_free;
    logic                div_start;
    logic [DW-1:0]       div_dividend;
    logic                div_done;
    logic [DW-1:0]       div_quo;
    logic [GROUP_W-1:0]  div_rem;
    logic [15:0]         cop_mask;
    logic [GROUP_W-1:0]  res_inc;
    logic [GROUP_W-1:0]  chan_inc;

    always_comb
    begin
        if (cfg.group_size == '0)
            g_eff = GROUP_W'(1);
        else if (cfg.group_size > GROUP_W'(MAX_GROUP))
            g_eff = GROUP_W'(MAX_GROUP);
        else
            g_eff = cfg.group_size;
        if (DW'(cfg.node_count) > DW'(MAX_NODES))
            n_eff = DW'(MAX_NODES);
        else
            n_eff = DW'(cfg.node_count);
    end

    assign cmd_stall = (state_reg != ST_IDLE);
    assign accept    = cmd_valid && !cmd_stall;
    assign out_free  = !cell_valid_reg || !cell_stall;
    assign cop_mask  = coprime_mask(g_eff);
    assign res_inc   = {1'b0, res_reg} + 1'b1;
    assign chan_inc  = {1'b0, dn_chan_reg} + 1'b1;

    // divider runs for ceil(N/G) first, then for (1 + ceil(N/G) + N) mod G
    always_comb
    begin
        div_start    = 1'b0;
        div_dividend = n_eff + DW'(g_eff) - DW'(1);
        if (state_reg == ST_IDLE)
            div_start = accept && (cmd.command == CMD_START);
        else if (state_reg == ST_DIV_N && div_done)
        begin
            div_start    = 1'b1;
            div_dividend = DW'(1) + div_quo + n_eff;
        end
    end

    tca_div #(
        .DW (DW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (g_eff),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    always_comb
    begin
        state_next      = state_reg;
        frame_len_next  = frame_len_reg;
        up_slot_next    = up_slot_reg;
        dn_slot_next    = dn_slot_reg;
        dn_chan_next    = dn_chan_reg;
        done_cnt_next   = done_cnt_reg;
        addr_next       = addr_reg;
        ovf_next        = ovf_reg;
        q_next          = q_reg;
        cand_next       = cand_reg;
        res_next        = res_reg;
        cell_next       = cell_reg;
        cell_valid_next = cell_valid_reg && cell_stall;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (cmd.command == CMD_START)
                        state_next = ST_DIV_N;
                    else
                    begin
                        addr_next  = cmd.node_address;
                        ovf_next   = (DW'(done_cnt_reg) >= n_eff);
                        state_next = ST_EMIT_UP;
                    end
                end
            end
            ST_DIV_N:
            begin
                if (div_done)
                begin
                    q_next     = div_quo;
                    cand_next  = div_dividend;
                    state_next = ST_DIV_START;
                end
            end
            ST_DIV_START:
            begin
                if (div_done)
                begin
                    res_next   = div_rem[CHAN_W-1:0];
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                if (cop_mask[res_reg])
                begin
                    frame_len_next = cand_reg[SLOT_W-1:0];
                    up_slot_next   = SLOT_W'(q_reg + DW'(1));
                    dn_slot_next   = SLOT_W'(1);
                    dn_chan_next   = '0;
                    done_cnt_next  = '0;
                    state_next     = ST_EMIT_START;
                end
                else
                begin
                    cand_next = cand_reg + DW'(1);
                    res_next  = (res_inc == g_eff) ? '0 : res_inc[CHAN_W-1:0];
                end
            end
            ST_EMIT_START:
            begin
                if (out_free)
                begin
                    cell_valid_next        = 1'b1;
                    cell_next.slot         = '0;
                    cell_next.channel      = '0;
                    cell_next.sender       = cfg.node_broadcast_addr;
                    cell_next.receiver     = cfg.router_broadcast_addr;
                    cell_next.shared       = 1'b1;
                    cell_next.frame_length = frame_len_reg;
                    cell_next.overflow     = 1'b0;
                    cell_next.last         = 1'b1;
                    state_next             = ST_IDLE;
                end
            end
            ST_EMIT_UP:
            begin
                if (out_free)
                begin
                    cell_valid_next        = 1'b1;
                    cell_next.slot         = up_slot_reg;
                    cell_next.channel      = '0;
                    cell_next.sender       = addr_reg;
                    cell_next.receiver     = cfg.router_broadcast_addr;
                    cell_next.shared       = 1'b0;
                    cell_next.frame_length = frame_len_reg;
                    cell_next.overflow     = ovf_reg;
                    cell_next.last         = 1'b0;
                    state_next             = ST_EMIT_DOWN;
                end
            end
            ST_EMIT_DOWN:
            begin
                if (out_free)
                begin
                    cell_valid_next        = 1'b1;
                    cell_next.slot         = dn_slot_reg;
                    cell_next.channel      = dn_chan_reg;
                    cell_next.sender       = cfg.router_broadcast_addr;
                    cell_next.receiver     = addr_reg;
                    cell_next.shared       = 1'b0;
                    cell_next.frame_length = frame_len_reg;
                    cell_next.overflow     = ovf_reg;
                    cell_next.last         = 1'b1;
                    up_slot_next           = up_slot_reg + 1'b1;
                    // wrap at or above the current group size
                    if (chan_inc >= g_eff)
                    begin
                        dn_chan_next = '0;
                        dn_slot_next = dn_slot_reg + 1'b1;
                    end
                    else
                        dn_chan_next = chan_inc[CHAN_W-1:0];
                    if (done_cnt_reg != '1)
                        done_cnt_next = done_cnt_reg + 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            frame_len_reg  <= SLOT_W'(1);
            up_slot_reg    <= '0;
            dn_slot_reg    <= SLOT_W'(1);
            dn_chan_reg    <= '0;
            done_cnt_reg   <= '0;
            addr_reg       <= '0;
            ovf_reg        <= 1'b0;
            q_reg          <= '0;
            cand_reg       <= '0;
            res_reg        <= '0;
            cell_valid_reg <= 1'b0;
            cell_reg       <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            frame_len_reg  <= frame_len_next;
            up_slot_reg    <= up_slot_next;
            dn_slot_reg    <= dn_slot_next;
            dn_chan_reg    <= dn_chan_next;
            done_cnt_reg   <= done_cnt_next;
            addr_reg       <= addr_next;
            ovf_reg        <= ovf_next;
            q_reg          <= q_next;
            cand_reg       <= cand_next;
            res_reg        <= res_next;
            cell_valid_reg <= cell_valid_next;
            cell_reg       <= cell_next;
        end
    end

    assign cell_valid = cell_valid_reg;
    assign cell_data  = cell_reg;

`ifndef SYNTHESIS
    // the shared cell is always the single start cell at slot 0, channel 0
    assert property (@(posedge clk) disable iff (!rst_n)
        (cell_valid && cell_data.shared) |->
            (cell_data.last && cell_data.slot == '0 && cell_data.channel == '0))
        else $error("shared cell with wrong slot, channel or last flag");

    // an uplink beat is never directly followed by another uplink beat
    assert property (@(posedge clk) disable iff (!rst_n)
        (cell_valid && !cell_stall && !cell_data.last) |=>
            !(cell_valid && !cell_data.last))
        else $error("uplink beat not followed by its downlink beat");

    // divider completions only land while the sequencer waits for them
    assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_DIV_N || state_reg == ST_DIV_START))
        else $error("divider done outside a divide state");
`endif

endmodule
